FILE: rtl/midi_running_status_parser_defines.svh
// ----------------------------------------------------------------------------
// MIDI running status parser: assertion macros
// Shared property shorthands for the parser modules.
// ----------------------------------------------------------------------------
`ifndef MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH
`define MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MRSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MRSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Item types, message length codes and status decode.
// ----------------------------------------------------------------------------
package mrsp_pkg;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 7;
    localparam int TIME_W = 64;
    localparam int LEN_W  = 2;

    // message length codes
    localparam logic [LEN_W-1:0] LEN_NONE     = 2'd0;
    localparam logic [LEN_W-1:0] LEN_REALTIME = 2'd1;
    localparam logic [LEN_W-1:0] LEN_SHORT    = 2'd2;
    localparam logic [LEN_W-1:0] LEN_FULL     = 2'd3;

    // status high nibbles
    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_POLY_PRESS = 4'hA;
    localparam logic [3:0] ST_CTRL_CHG   = 4'hB;
    localparam logic [3:0] ST_PROG_CHG   = 4'hC;
    localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
    localparam logic [3:0] ST_PITCH_BEND = 4'hE;

    // top five bits of real-time (F8..FF) and system common/SysEx (F0..F7)
    localparam logic [4:0] PFX_REALTIME = 5'b11111;
    localparam logic [4:0] PFX_SYSTEM   = 5'b11110;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [TIME_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0]  message_length;
        logic [BYTE_W-1:0] status_byte;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
        logic [TIME_W-1:0] message_time;
    } t_out_item;

    // message length opened by a status byte, LEN_NONE if it opens none
    function automatic logic [LEN_W-1:0] len_of_status(input logic [BYTE_W-1:0] st);
        logic [LEN_W-1:0] len;
        len = LEN_NONE;
        if (st[7]) begin
            case (st[7:4])
                ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL_CHG,
                ST_PITCH_BEND: len = LEN_FULL;
                ST_PROG_CHG, ST_CHAN_PRESS: len = LEN_SHORT;
                default: len = LEN_NONE;
            endcase
        end
        return len;
    endfunction

endpackage

FILE: rtl/mrsp_in_if.sv
// ----------------------------------------------------------------------------
// MIDI byte channel
// valid/ready channel carrying one stream byte and its time tag.
// ----------------------------------------------------------------------------
interface mrsp_in_if;
    import mrsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [TIME_W-1:0] timestamp;

    modport source (output valid, output data_byte, output timestamp, input ready);
    modport sink   (input valid, input data_byte, input timestamp, output ready);
endinterface

FILE: rtl/mrsp_out_if.sv
// ----------------------------------------------------------------------------
// MIDI message channel
// valid/ready channel carrying one parsed message.
// ----------------------------------------------------------------------------
interface mrsp_out_if;
    import mrsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  message_length;
    logic [BYTE_W-1:0] status_byte;
    logic [DATA_W-1:0] first_data;
    logic [DATA_W-1:0] second_data;
    logic [TIME_W-1:0] message_time;

    modport source (output valid, output message_length, output status_byte,
                    output first_data, output second_data, output message_time,
                    input ready);
    modport sink   (input valid, input message_length, input status_byte,
                    input first_data, input second_data, input message_time,
                    output ready);
endinterface

FILE: rtl/midi_running_status_parser.sv
// Path: an accepted byte waits in the input register, then the core registers its
//   message in the result register, which drives o_out, once that register is free.
// Throughput: one byte item per cycle; a byte is taken every cycle the result
//   register is empty or being drained, and the input register holds one more.
// Reset (i_rst_n low, synchronous): running status cleared, no message open,
//   both stage registers empty. Held data bytes are not cleared.
// ----------------------------------------------------------------------------
// MIDI running status parser
// Groups a MIDI byte stream into channel messages with time tags.
// ----------------------------------------------------------------------------
module midi_running_status_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrsp_in_if.sink    i_in,
    mrsp_out_if.source o_out
);
    import mrsp_pkg::*;

    // input register -> core (state update) -> result register
    logic      in_valid;
    t_in_item  in_item;
    logic      out_ready;
    logic      take;
    logic      emit;
    t_out_item res_item;

    // core consumes the held byte whenever the result register has room;
    // bytes that finish no message still advance
    assign take = in_valid && out_ready;

    mrsp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    mrsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (in_item),
        .o_emit  (emit),
        .o_item  (res_item)
    );

    mrsp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_item  (res_item),
        .o_ready (out_ready),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/mrsp_in_stage.sv
// ----------------------------------------------------------------------------
// MIDI parser input register
// Captures one byte item; frees itself when the core consumes it.
// ----------------------------------------------------------------------------
module mrsp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrsp_in_if.sink           i_in,
    input  logic              i_take,
    output logic              o_valid,
    output mrsp_pkg::t_in_item o_item
);
    import mrsp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.timestamp <= i_in.timestamp;
        end
    end

endmodule

FILE: rtl/mrsp_core.sv
// ----------------------------------------------------------------------------
// MIDI parser core
// Running status and partial message state, one byte per take.
// ----------------------------------------------------------------------------
`include "midi_running_status_parser_defines.svh"

module mrsp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  mrsp_pkg::t_in_item  i_item,
    output logic                o_emit,
    output mrsp_pkg::t_out_item o_item
);
    import mrsp_pkg::*;

    // open message status always equals the running status, so only the
    // first data byte of a 3-byte message needs holding
    logic [BYTE_W-1:0] r_running, n_running;
    logic [DATA_W-1:0] r_first,   n_first;
    logic [LEN_W-1:0]  r_held,    n_held;
    logic [LEN_W-1:0]  r_needed,  n_needed;

    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  st_len;
    logic [LEN_W-1:0]  cur_needed;
    logic [LEN_W-1:0]  cur_held;
    logic [LEN_W-1:0]  new_held;
    logic              emit;

    assign b = i_item.data_byte;

    always_comb begin
        n_running  = r_running;
        n_first    = r_first;
        n_held     = r_held;
        n_needed   = r_needed;
        emit       = 1'b0;
        o_item     = '0;
        o_item.message_time = i_item.timestamp;
        st_len     = len_of_status(b);
        cur_needed = (r_needed != LEN_NONE) ? r_needed : len_of_status(r_running);
        cur_held   = (r_needed != LEN_NONE) ? r_held : 2'd1;
        new_held   = cur_held + 2'd1;

        if (b[7:3] == PFX_REALTIME) begin
            // real-time: pass through, state untouched
            emit                  = 1'b1;
            o_item.message_length = LEN_REALTIME;
            o_item.status_byte    = b;
        end else if (b[7]) begin
            if (st_len != LEN_NONE) begin
                n_running = b;
                n_held    = 2'd1;
                n_needed  = st_len;
            end else begin
                n_running = '0;
                n_held    = 2'd0;
                n_needed  = LEN_NONE;
            end
        end else if (cur_needed != LEN_NONE) begin
            if (cur_held == 2'd1) begin
                n_first = b[DATA_W-1:0];
            end
            if (new_held >= cur_needed) begin
                emit                  = 1'b1;
                o_item.message_length = cur_needed;
                o_item.status_byte    = r_running;
                o_item.first_data     = (cur_held == 2'd1) ? b[DATA_W-1:0] : r_first;
                o_item.second_data    = (cur_needed == LEN_FULL) ? b[DATA_W-1:0] : '0;
                n_held                = 2'd0;
                n_needed              = LEN_NONE;
            end else begin
                n_held   = new_held;
                n_needed = cur_needed;
            end
        end
    end

    assign o_emit = i_take && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_held    <= 2'd0;
            r_needed  <= LEN_NONE;
        end else if (i_take) begin
            r_running <= n_running;
            r_held    <= n_held;
            r_needed  <= n_needed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_first <= n_first;
        end
    end

    `MRSP_ASSERT_NOW(a_held_in_range, r_needed != LEN_NONE, r_held != 2'd0 && r_held < r_needed, "open message byte count out of range")
    `MRSP_ASSERT_NEXT(a_system_clears, i_take && b[7:3] == PFX_SYSTEM, r_needed == LEN_NONE && r_running == '0, "system byte did not clear running status")
    `MRSP_ASSERT_NEXT(a_emit_keeps_status, o_emit && o_item.message_length != LEN_REALTIME, r_running == $past(r_running), "running status changed on message completion")

endmodule

FILE: rtl/mrsp_out_stage.sv
// ----------------------------------------------------------------------------
// MIDI parser result register
// Holds one finished message until the sink takes it.
// ----------------------------------------------------------------------------
module mrsp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mrsp_pkg::t_out_item i_item,
    output logic                o_ready,
    mrsp_out_if.source          o_out
);
    import mrsp_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_ready              = !r_valid || o_out.ready;
    assign o_out.valid          = r_valid;
    assign o_out.message_length = r_item.message_length;
    assign o_out.status_byte    = r_item.status_byte;
    assign o_out.first_data     = r_item.first_data;
    assign o_out.second_data    = r_item.second_data;
    assign o_out.message_time   = r_item.message_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: sim/midi_running_status_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running status parser: message checker
// Watches both channels, predicts each message from the accepted bytes and
// compares it field by field with what the parser emits.
// ----------------------------------------------------------------------------
module midi_running_status_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrsp_in_if         i_byte_ch,
    mrsp_out_if        i_msg_ch,
    output int         o_fail_count,
    output int         o_pending
);
    import mrsp_pkg::*;

    // parser state as seen from the byte stream
    logic [BYTE_W-1:0] run_status;
    logic [BYTE_W-1:0] msg_buf [3];
    logic [1:0]        held_cnt;
    logic [LEN_W-1:0]  need_len;

    t_out_item         pending_msgs[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        run_status   = '0;
        held_cnt     = '0;
        need_len     = LEN_NONE;
    end

    // bytes a status opens, LEN_NONE for system bytes and data
    function automatic logic [LEN_W-1:0] status_span(input logic [BYTE_W-1:0] st);
        logic [LEN_W-1:0] span;
        span = LEN_NONE;
        if (st[7]) begin
            unique case (st[7:4])
                ST_PROG_CHG, ST_CHAN_PRESS: span = LEN_SHORT;
                ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL_CHG,
                ST_PITCH_BEND: span = LEN_FULL;
                default: span = LEN_NONE;
            endcase
        end
        return span;
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] ts);
        t_out_item        msg;
        logic [LEN_W-1:0] span;
        msg = '0;
        msg.message_time = ts;
        if (b[7:3] == PFX_REALTIME) begin
            // real-time passes straight through, open message untouched
            msg.message_length = LEN_REALTIME;
            msg.status_byte    = b;
            pending_msgs.push_back(msg);
            return;
        end
        if (b[7]) begin
            span = status_span(b);
            if (span != LEN_NONE) begin
                run_status = b;
                msg_buf[0] = b;
                held_cnt   = 2'd1;
                need_len   = span;
            end else begin
                run_status = '0;
                held_cnt   = '0;
                need_len   = LEN_NONE;
            end
            return;
        end
        if (need_len == LEN_NONE) begin
            span = status_span(run_status);
            if (span == LEN_NONE) return;
            msg_buf[0] = run_status;
            held_cnt   = 2'd1;
            need_len   = span;
        end
        if (held_cnt < 2'd3) msg_buf[held_cnt] = b;
        held_cnt = held_cnt + 2'd1;
        if (held_cnt >= need_len) begin
            msg.message_length = need_len;
            msg.status_byte    = msg_buf[0];
            msg.first_data     = msg_buf[1][DATA_W-1:0];
            msg.second_data    = (need_len == LEN_FULL) ? msg_buf[2][DATA_W-1:0] : '0;
            pending_msgs.push_back(msg);
            held_cnt = '0;
            need_len = LEN_NONE;
        end
    endtask

    task automatic check_message();
        t_out_item want;
        if (pending_msgs.size() == 0) begin
            $error("unexpected message: status %02h length %0d",
                   i_msg_ch.status_byte, i_msg_ch.message_length);
            o_fail_count++;
            return;
        end
        want = pending_msgs.pop_front();
        if (i_msg_ch.message_length !== want.message_length) begin
            $error("message_length: expected %0d, got %0d",
                   want.message_length, i_msg_ch.message_length);
            o_fail_count++;
        end
        if (i_msg_ch.status_byte !== want.status_byte) begin
            $error("status_byte: expected %02h, got %02h",
                   want.status_byte, i_msg_ch.status_byte);
            o_fail_count++;
        end
        if (i_msg_ch.first_data !== want.first_data) begin
            $error("first_data: expected %02h, got %02h",
                   want.first_data, i_msg_ch.first_data);
            o_fail_count++;
        end
        if (i_msg_ch.second_data !== want.second_data) begin
            $error("second_data: expected %02h, got %02h",
                   want.second_data, i_msg_ch.second_data);
            o_fail_count++;
        end
        if (i_msg_ch.message_time !== want.message_time) begin
            $error("message_time: expected %016h, got %016h",
                   want.message_time, i_msg_ch.message_time);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_status = '0;
            held_cnt   = '0;
            need_len   = LEN_NONE;
            pending_msgs.delete();
        end else begin
            if (i_msg_ch.valid && i_msg_ch.ready) check_message();
            if (i_byte_ch.valid && i_byte_ch.ready)
                parse_byte(i_byte_ch.data_byte, i_byte_ch.timestamp);
        end
        o_pending = pending_msgs.size();
    end

endmodule

FILE: sim/midi_running_status_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running status parser: testbench top
// Feeds directed and random MIDI byte streams with random gaps and output
// stalls; the checker beside the parser predicts and compares every message.
// ----------------------------------------------------------------------------
module midi_running_status_parser_test;
    import mrsp_pkg::*;

    localparam int STREAM_TARGET = 1750;   // bytes in the whole run
    localparam int QUIET_AFTER   = 1500;   // no gaps or stalls past this point
    localparam int HOLD_AT       = 900;    // drain the parser once here

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet;        // turns off idling on both sides
    int   fed;          // bytes sent so far
    int   run_span;     // length the parser's running status implies, 0 if none

    mrsp_in_if  byte_ch ();
    mrsp_out_if msg_ch ();

    midi_running_status_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (msg_ch)
    );

    midi_running_status_parser_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .i_msg_ch     (msg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop, well above the slowest legal run.
    initial begin
        #2_000_000;
        $display("** midi_running_status_parser: FAILED **");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_data();
        return {1'b0, 7'($urandom_range(0, 127))};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_realtime();
        return {PFX_REALTIME, 3'($urandom_range(0, 7))};
    endfunction

    // One byte item; may idle first. Returns after the accepting edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] ts);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                byte_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.timestamp <= ts;
        do @(posedge i_clk); while (!byte_ch.ready);
        fed++;
        // follow what the running status will be, so reused-status
        // messages get the right number of data bytes
        if (b[7:3] == PFX_SYSTEM)
            run_span = 0;
        else if (b[7] && b[7:3] != PFX_REALTIME)
            run_span = (b[7:4] == ST_PROG_CHG || b[7:4] == ST_CHAN_PRESS) ? 2 : 3;
    endtask

    // Hold the sender until every predicted message has come out.
    task automatic drain();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Channel message, with a fresh status or on the running status;
    // real-time bytes are mixed in between now and then.
    task automatic send_channel_msg(input bit fresh, input int keep);
        logic [3:0]        hi;
        logic [BYTE_W-1:0] st;
        int                span;
        int                k;
        case ($urandom_range(0, 6))
            0: hi = ST_NOTE_OFF;
            1: hi = ST_NOTE_ON;
            2: hi = ST_POLY_PRESS;
            3: hi = ST_CTRL_CHG;
            4: hi = ST_PROG_CHG;
            5: hi = ST_CHAN_PRESS;
            default: hi = ST_PITCH_BEND;
        endcase
        st   = {hi, 4'($urandom_range(0, 15))};
        span = (hi == ST_PROG_CHG || hi == ST_CHAN_PRESS) ? 2 : 3;
        if (!fresh && run_span != 0)
            span = run_span;
        else begin
            send_byte(st, rand_time());
        end
        // keep < span - 1 truncates the message
        for (k = 1; k < span && k <= keep; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(rand_realtime(), rand_time());
            end
            send_byte(rand_data(), rand_time());
        end
    endtask

    // drive the sink side: long ready stretches broken by short stalls
    initial begin
        int hold;
        int stall;
        msg_ch.ready = 1'b0;
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
            repeat (hold) begin
                @(negedge i_clk);
                msg_ch.ready <= 1'b1;
            end
            if (!quiet) begin
                stall = $urandom_range(1, 6);
                repeat (stall) begin
                    @(negedge i_clk);
                    msg_ch.ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        int  pick;
        int  k;
        int  n;
        bit  held_once;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.timestamp = '0;
        i_rst_n           = 1'b0;
        quiet             = 1'b0;
        fed               = 0;
        run_span          = 0;
        held_once         = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // data with no running status after reset: dropped
        send_byte(8'h00, 64'd0);
        send_byte(8'h7F, rand_time());
        // note on, full message, extreme data and timestamps
        send_byte(8'h90, rand_time());
        send_byte(8'h00, rand_time());
        send_byte(8'h7F, 64'hFFFF_FFFF_FFFF_FFFF);
        // running status reuse, real-time byte in the middle
        send_byte(8'h12, rand_time());
        send_byte(8'hF8, 64'd0);
        send_byte(8'h34, rand_time());
        // program change, then reused
        send_byte(8'hC5, rand_time());
        send_byte(8'h7F, rand_time());
        send_byte(8'h05, rand_time());
        // new status while control change is open: old one discarded
        send_byte(8'hB0, rand_time());
        send_byte(8'h07, rand_time());
        send_byte(8'hEF, rand_time());
        send_byte(8'h00, rand_time());
        send_byte(8'h40, rand_time());
        // SysEx clears running status; following data dropped
        send_byte(8'hF0, rand_time());
        send_byte(8'h11, rand_time());
        send_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // channel pressure
        send_byte(8'hD0, rand_time());
        send_byte(8'h22, rand_time());
        // system common inside a note off discards it
        send_byte(8'h80, rand_time());
        send_byte(8'h3C, rand_time());
        send_byte(8'hF3, rand_time());
        send_byte(8'h40, rand_time());
        // poly pressure
        send_byte(8'hAF, rand_time());
        send_byte(8'h01, rand_time());
        send_byte(8'h02, rand_time());

        drain();

        // ---- random part ----
        while (fed < STREAM_TARGET) begin
            if (fed >= QUIET_AFTER) quiet = 1'b1;
            if (!held_once && fed >= HOLD_AT) begin
                drain();
                held_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_channel_msg($urandom_range(0, 3) != 0, 2);
            end else if (pick < 78) begin
                // SysEx block, end marker sometimes missing
                send_byte(8'hF0, rand_time());
                n = $urandom_range(0, 5);
                for (k = 0; k < n; k++) send_byte(rand_data(), rand_time());
                if ($urandom_range(0, 3) != 0) send_byte(8'hF7, rand_time());
            end else if (pick < 85) begin
                // system common with its data
                send_byte({PFX_SYSTEM, 3'($urandom_range(1, 6))}, rand_time());
                n = $urandom_range(0, 2);
                for (k = 0; k < n; k++) send_byte(rand_data(), rand_time());
            end else if (pick < 93) begin
                // possibly truncated message, cut off by whatever comes next
                send_channel_msg(1'b1, $urandom_range(0, 1));
            end else begin
                send_byte(8'($urandom_range(0, 255)), rand_time());
            end
        end

        // ---- wind down ----
        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** midi_running_status_parser: PASSED **");
        end else begin
            $display("** midi_running_status_parser: FAILED **");
        end
        $finish;
    end

endmodule

FILE: midi_running_status_parser.f
+incdir+rtl
rtl/mrsp_pkg.sv
rtl/mrsp_in_if.sv
rtl/mrsp_out_if.sv
rtl/mrsp_in_stage.sv
rtl/mrsp_core.sv
rtl/mrsp_out_stage.sv
rtl/midi_running_status_parser.sv
sim/midi_running_status_parser_checker.sv
sim/midi_running_status_parser_test.sv
